// ===== hdl/isofr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isofr_pkg;

    // Field widths of the packet descriptor and of the status word.
    localparam int unsigned PKT_LEN_W   = 11;
    localparam int unsigned MARKER_W    = 16;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned RATE_HZ_W   = 17;
    localparam int unsigned PROGRESS_W  = 15;
    localparam int unsigned PAIR_CODE_W = 4;
    localparam int unsigned SAMPLES_W   = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [PKT_LEN_W-1:0] MAX_PACKET_BYTES = PKT_LEN_W'(1024);

    // Header markers: bytes 1:0 all 0xAA, bytes 17:16 all 0x55.
    localparam logic [MARKER_W-1:0] HDR_START = {2{8'hAA}};
    localparam logic [MARKER_W-1:0] HDR_END   = {2{8'h55}};

    // Frame layout: fixed header bytes plus 6 bytes per channel pair per sample.
    localparam int unsigned HDR_BYTES       = 18;
    localparam int unsigned BYTES_PER_PAIR  = 6;
    localparam int unsigned SAMPLES_RST     = 64;
    localparam int unsigned PAIR_CODE_RST   = 0;

    // Rate snapping. The count is in tens of hertz and must lie strictly
    // within the window around a nominal rate.
    localparam int unsigned HZ_PER_COUNT = 10;
    localparam int unsigned SNAP_WINDOW  = 300;
    localparam int unsigned RATE_44K1_HZ = 44100;
    localparam int unsigned RATE_48K_HZ  = 48000;
    localparam int unsigned RATE_88K2_HZ = 88200;
    localparam int unsigned RATE_96K_HZ  = 96000;

    localparam logic [COUNT_W-1:0] SNAP_LO_44K1 =
        COUNT_W'((RATE_44K1_HZ - SNAP_WINDOW) / HZ_PER_COUNT + 1);
    localparam logic [COUNT_W-1:0] SNAP_HI_44K1 =
        COUNT_W'((RATE_44K1_HZ + SNAP_WINDOW - 1) / HZ_PER_COUNT);
    localparam logic [COUNT_W-1:0] SNAP_LO_48K =
        COUNT_W'((RATE_48K_HZ - SNAP_WINDOW) / HZ_PER_COUNT + 1);
    localparam logic [COUNT_W-1:0] SNAP_HI_48K =
        COUNT_W'((RATE_48K_HZ + SNAP_WINDOW - 1) / HZ_PER_COUNT);
    localparam logic [COUNT_W-1:0] SNAP_LO_88K2 =
        COUNT_W'((RATE_88K2_HZ - SNAP_WINDOW) / HZ_PER_COUNT + 1);
    localparam logic [COUNT_W-1:0] SNAP_HI_88K2 =
        COUNT_W'((RATE_88K2_HZ + SNAP_WINDOW - 1) / HZ_PER_COUNT);
    localparam logic [COUNT_W-1:0] SNAP_LO_96K =
        COUNT_W'((RATE_96K_HZ - SNAP_WINDOW) / HZ_PER_COUNT + 1);
    localparam logic [COUNT_W-1:0] SNAP_HI_96K =
        COUNT_W'((RATE_96K_HZ + SNAP_WINDOW - 1) / HZ_PER_COUNT);

    typedef logic [2:0] rate_code_t;
    localparam rate_code_t RATE_NONE    = 3'd0;
    localparam rate_code_t RATE_44K1    = 3'd1;
    localparam rate_code_t RATE_48K     = 3'd2;
    localparam rate_code_t RATE_88K2    = 3'd3;
    localparam rate_code_t RATE_96K     = 3'd4;
    localparam rate_code_t RATE_UNKNOWN = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_PAIR_CODE = 2'd0,
        REG_SAMPLES      = 2'd1
    } cfg_reg_e;

    typedef struct packed {
        logic                  packet_ok;
        logic [PKT_LEN_W-1:0]  packet_length;
        logic [MARKER_W-1:0]   start_marker;
        logic [MARKER_W-1:0]   end_marker;
        logic [LEVEL_W-1:0]    fifo_level_byte;
        logic [COUNT_W-1:0]    skip_word;
        logic [COUNT_W-1:0]    rate_count;
        logic [COUNT_W-1:0]    full_word;
        logic [COUNT_W-1:0]    iso_err_word;
    } in_word_t;

    typedef struct packed {
        logic                  frame_complete;
        logic                  header_seen;
        logic [RATE_HZ_W-1:0]  rate_hz;
        logic                  rate_changed;
        logic [LEVEL_W-1:0]    fifo_level;
        logic [COUNT_W-1:0]    out_skip_count;
        logic [COUNT_W-1:0]    in_full_count;
        logic [COUNT_W-1:0]    iso_error_count;
        logic [COUNT_W-1:0]    resync_errors;
        logic [PROGRESS_W-1:0] frame_progress;
    } out_word_t;

    // Frame size in bytes: 18 + 6 * (code + 1) * samples. At most 24498.
    function automatic logic [PROGRESS_W-1:0] frame_bytes(
        input logic [PAIR_CODE_W-1:0] pair_code,
        input logic [SAMPLES_W-1:0]   samples
    );
        logic [PAIR_CODE_W:0]             pairs;
        logic [PAIR_CODE_W+SAMPLES_W:0]   slots;
        logic [PAIR_CODE_W+SAMPLES_W+3:0] bytes;
        pairs = {1'b0, pair_code} + (PAIR_CODE_W+1)'(1);
        slots = (PAIR_CODE_W+SAMPLES_W+1)'(pairs) * (PAIR_CODE_W+SAMPLES_W+1)'(samples);
        bytes = (PAIR_CODE_W+SAMPLES_W+4)'(slots) * (PAIR_CODE_W+SAMPLES_W+4)'(BYTES_PER_PAIR)
              + (PAIR_CODE_W+SAMPLES_W+4)'(HDR_BYTES);
        return PROGRESS_W'(bytes);
    endfunction

    function automatic rate_code_t snap_code(input logic [COUNT_W-1:0] count);
        rate_code_t code;
        priority if (count >= SNAP_LO_44K1 && count <= SNAP_HI_44K1)
            code = RATE_44K1;
        else if (count >= SNAP_LO_48K && count <= SNAP_HI_48K)
            code = RATE_48K;
        else if (count >= SNAP_LO_88K2 && count <= SNAP_HI_88K2)
            code = RATE_88K2;
        else if (count >= SNAP_LO_96K && count <= SNAP_HI_96K)
            code = RATE_96K;
        else
            code = RATE_NONE;
        return code;
    endfunction

    function automatic logic [RATE_HZ_W-1:0] rate_hz_of(input rate_code_t code);
        logic [RATE_HZ_W-1:0] hz;
        unique case (code)
            RATE_44K1: hz = RATE_HZ_W'(RATE_44K1_HZ);
            RATE_48K:  hz = RATE_HZ_W'(RATE_48K_HZ);
            RATE_88K2: hz = RATE_HZ_W'(RATE_88K2_HZ);
            RATE_96K:  hz = RATE_HZ_W'(RATE_96K_HZ);
            default:   hz = '0;
        endcase
        return hz;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/isofr_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isofr_in_stage
    import isofr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_word_t in_data,
    output logic          s1_valid,
    input  wire logic     s1_take,
    output in_word_t      s1_data
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t data_reg;
    logic     load;

    // The register can refill in the same cycle that its word moves on.
    assign in_ready = !valid_reg || s1_take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (s1_take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= in_data;
    end

    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/isofr_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isofr_cfg
    import isofr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic [PROGRESS_W-1:0]      frame_size
);

    logic [PAIR_CODE_W-1:0] pair_code_reg;
    logic [PAIR_CODE_W-1:0] pair_code_next;
    logic [SAMPLES_W-1:0]   samples_reg;
    logic [SAMPLES_W-1:0]   samples_next;
    logic [PROGRESS_W-1:0]  frame_size_reg;
    logic [PROGRESS_W-1:0]  frame_size_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        pair_code_next = pair_code_reg;
        samples_next   = samples_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IN_PAIR_CODE: pair_code_next = cfg_data[PAIR_CODE_W-1:0];
                REG_SAMPLES:      samples_next   = cfg_data[SAMPLES_W-1:0];
                default:          ;
            endcase
        end
        // The frame size is kept ready so the packet path only adds and compares.
        frame_size_next = frame_bytes(pair_code_next, samples_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_code_reg  <= PAIR_CODE_W'(PAIR_CODE_RST);
            samples_reg    <= SAMPLES_W'(SAMPLES_RST);
            frame_size_reg <= frame_bytes(PAIR_CODE_W'(PAIR_CODE_RST), SAMPLES_W'(SAMPLES_RST));
        end
        else
        begin
            pair_code_reg  <= pair_code_next;
            samples_reg    <= samples_next;
            frame_size_reg <= frame_size_next;
        end
    end

    assign frame_size = frame_size_reg;

endmodule

`default_nettype wire

// ===== hdl/isofr_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isofr_tracker
    import isofr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s1_valid,
    output logic                       s1_take,
    input  wire in_word_t              s1_data,
    input  wire logic [PROGRESS_W-1:0] frame_size,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_word_t                  out_data
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  complete_reg;
    logic                  complete_next;
    logic                  header_reg;
    logic                  header_next;
    logic                  changed_reg;
    logic                  changed_next;
    logic [PROGRESS_W-1:0] progress_reg;
    logic [PROGRESS_W-1:0] progress_next;
    logic [COUNT_W-1:0]    resync_reg;
    logic [COUNT_W-1:0]    resync_next;
    rate_code_t            rate_code_reg;
    rate_code_t            rate_code_next;
    logic [LEVEL_W-1:0]    fifo_level_reg;
    logic [LEVEL_W-1:0]    fifo_level_next;
    logic [COUNT_W-1:0]    skip_reg;
    logic [COUNT_W-1:0]    skip_next;
    logic [COUNT_W-1:0]    full_reg;
    logic [COUNT_W-1:0]    full_next;
    logic [COUNT_W-1:0]    iso_err_reg;
    logic [COUNT_W-1:0]    iso_err_next;

    logic [PKT_LEN_W-1:0]  len_clamped;
    logic                  is_header;
    logic                  counts;
    logic [PROGRESS_W-1:0] grown;
    logic                  bump;
    rate_code_t            snapped;

    // State only moves when a result is loaded, so the result register and
    // the held state always agree while a word waits at the output.
    assign s1_take = s1_valid && (!out_valid_reg || out_ready);

    assign len_clamped = (s1_data.packet_length > MAX_PACKET_BYTES) ?
                         MAX_PACKET_BYTES : s1_data.packet_length;
    assign is_header   = (s1_data.start_marker == HDR_START) &&
                         (s1_data.end_marker == HDR_END);
    assign counts      = s1_data.packet_ok && (s1_data.packet_length != '0);
    assign snapped     = snap_code(s1_data.rate_count);

    always_comb
    begin
        complete_next   = 1'b0;
        header_next     = 1'b0;
        changed_next    = 1'b0;
        progress_next   = progress_reg;
        resync_next     = resync_reg;
        rate_code_next  = rate_code_reg;
        fifo_level_next = fifo_level_reg;
        skip_next       = skip_reg;
        full_next       = full_reg;
        iso_err_next    = iso_err_reg;
        grown           = progress_reg;
        bump            = 1'b0;

        if (counts)
        begin
            if (is_header)
            begin
                header_next     = 1'b1;
                changed_next    = (rate_code_reg != snapped) &&
                                  (rate_code_reg != RATE_UNKNOWN) &&
                                  (rate_code_reg != RATE_NONE);
                rate_code_next  = snapped;
                fifo_level_next = s1_data.fifo_level_byte;
                skip_next       = s1_data.skip_word;
                full_next       = s1_data.full_word;
                iso_err_next    = s1_data.iso_err_word;
                if (progress_reg == '0)
                    grown = PROGRESS_W'(len_clamped);
                else
                begin
                    // A header in the middle of a frame drops that frame.
                    grown = '0;
                    bump  = 1'b1;
                end
            end
            else if (progress_reg != '0)
                grown = progress_reg + PROGRESS_W'(len_clamped);
            else
            begin
                // Data with no frame open is thrown away.
                grown = '0;
                bump  = 1'b1;
            end

            // Frame size is never zero, so at most one resync event per packet.
            priority if (grown == frame_size)
            begin
                complete_next = 1'b1;
                progress_next = '0;
            end
            else if (grown > frame_size)
            begin
                bump          = 1'b1;
                progress_next = '0;
            end
            else
                progress_next = grown;

            if (bump && (resync_reg != '1))
                resync_next = resync_reg + COUNT_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (s1_take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            progress_reg   <= '0;
            resync_reg     <= '0;
            rate_code_reg  <= RATE_UNKNOWN;
            fifo_level_reg <= '0;
            skip_reg       <= '0;
            full_reg       <= '0;
            iso_err_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_take)
            begin
                progress_reg   <= progress_next;
                resync_reg     <= resync_next;
                rate_code_reg  <= rate_code_next;
                fifo_level_reg <= fifo_level_next;
                skip_reg       <= skip_next;
                full_reg       <= full_next;
                iso_err_reg    <= iso_err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            complete_reg <= complete_next;
            header_reg   <= header_next;
            changed_reg  <= changed_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_data.frame_complete  = complete_reg;
        out_data.header_seen     = header_reg;
        out_data.rate_hz         = rate_hz_of(rate_code_reg);
        out_data.rate_changed    = changed_reg;
        out_data.fifo_level      = fifo_level_reg;
        out_data.out_skip_count  = skip_reg;
        out_data.in_full_count   = full_reg;
        out_data.iso_error_count = iso_err_reg;
        out_data.resync_errors   = resync_reg;
        out_data.frame_progress  = progress_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/iso_frame_reassembler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Isochronous frame reassembler. Each input word describes one received
// isochronous packet (status, length and the header words at fixed byte
// offsets); each one yields exactly one status word in the same order. The
// block takes one packet word per clock cycle while the consumer keeps up.
// A word is first held in the input register and is then loaded into the
// result register, from which its status word is offered on the output.
// The frame tracking (a clamp, an add and a compare against the frame size)
// sits between the two registers. Output ready reaches input ready through
// a short combinational path, so the block keeps full rate while the
// consumer keeps up and holds two words when it stalls. The two
// configuration registers (channel pair code at index 0, samples per frame
// at index 1) are written through the config port, which is always ready;
// the frame size derived from them is registered on the write, so writes
// belong in idle periods only.

module iso_frame_reassembler_core
    import isofr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_word_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_word_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic                  s1_valid;
    logic                  s1_take;
    in_word_t              s1_data;
    logic [PROGRESS_W-1:0] frame_size;

    // Packet words are registered before any decoding.
    isofr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .s1_valid (s1_valid),
        .s1_take  (s1_take),
        .s1_data  (s1_data)
    );

    // Configuration registers and the precomputed frame size.
    isofr_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .frame_size (frame_size)
    );

    // Header detection, rate snapping, frame progress and the result word.
    isofr_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_take    (s1_take),
        .s1_data    (s1_data),
        .frame_size (frame_size),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/isofr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isofr_checker
    import isofr_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_word_t out_data
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // A completed frame leaves no bytes in progress.
    a_complete_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_complete |-> out_data.frame_progress == '0)
        else $error("frame complete with progress left");

    // Only a header can report a rate change.
    a_change_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.rate_changed |-> out_data.header_seen)
        else $error("rate change without header");

    // The reported rate is one of the snapped values.
    a_rate_snapped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.rate_hz == '0) ||
                      (out_data.rate_hz == RATE_HZ_W'(RATE_44K1_HZ)) ||
                      (out_data.rate_hz == RATE_HZ_W'(RATE_48K_HZ)) ||
                      (out_data.rate_hz == RATE_HZ_W'(RATE_88K2_HZ)) ||
                      (out_data.rate_hz == RATE_HZ_W'(RATE_96K_HZ)))
        else $error("rate not a snapped value");

endmodule

bind iso_frame_reassembler_core isofr_checker u_isofr_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_iso_frame_reassembler_core.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the isochronous frame reassembler. A driver and a
// monitor, both clocked always blocks, sit on the two valid/ready channels.
// The stimulus process fills a queue of packet words and writes the two
// configuration registers only while the block is idle. Every packet word
// that the block accepts runs through a local copy of the frame tracker. The
// status word that comes back is compared field by field with the oldest
// prediction.
module tb_iso_frame_reassembler_core;
    import isofr_pkg::*;

    // Each side stalls in roughly this many cycles out of a hundred, except
    // inside the calm window, which is counted in checked status words.
    localparam int unsigned IDLE_PERCENT  = 29;
    localparam int unsigned CALM_FROM     = 250;
    localparam int unsigned CALM_TO       = 550;
    // One long receiver hold-off, started once the sender has a deep backlog.
    localparam int unsigned HOLD_AFTER    = 600;
    localparam int unsigned HOLD_BACKLOG  = 16;
    localparam int unsigned HOLD_CYCLES   = 150;
    // Extra wait once every queued word has come back through the block.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PKT_MAX       = MAX_PACKET_BYTES;
    localparam int unsigned LEN_FIELD_MAX = (1 << PKT_LEN_W) - 1;

    // How a generated frame ends: filled exactly, cut short, or overrun.
    typedef enum int { FRAME_WHOLE, FRAME_CUT, FRAME_OVERRUN } frame_shape_e;
    // How the status bytes of a generated packet are filled.
    typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES } fill_e;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    iso_frame_reassembler_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Packet words waiting for the driver, and the status words that the
    // block owes us, oldest first.
    in_word_t    packets_to_send[$];
    out_word_t   status_due[$];

    // The queued and checked totals are written by one process each. The
    // block is idle once the two match.
    int unsigned queued_total  = 0;
    int unsigned checked_total = 0;
    int unsigned failures      = 0;
    int unsigned cycle_count   = 0;
    int unsigned settings_done = 0;
    int unsigned header_count  = 0;
    int unsigned frames_done   = 0;
    int unsigned rate_flips    = 0;

    // Local copy of the configuration and of the tracker state.
    logic [PAIR_CODE_W-1:0] pair_code_q    = PAIR_CODE_W'(PAIR_CODE_RST);
    logic [SAMPLES_W-1:0]   samples_q      = SAMPLES_W'(SAMPLES_RST);
    int unsigned            gathered       = 0;
    logic [COUNT_W-1:0]     resync_tally   = '0;
    rate_code_t             last_code      = RATE_UNKNOWN;
    logic [LEVEL_W-1:0]     held_level     = '0;
    logic [COUNT_W-1:0]     held_skip      = '0;
    logic [COUNT_W-1:0]     held_full      = '0;
    logic [COUNT_W-1:0]     held_iso       = '0;

    // Receiver hold-off bookkeeping, owned by the monitor alone.
    int unsigned hold_left = 0;
    bit          held_once = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int unsigned frame_len(input logic [PAIR_CODE_W-1:0] code,
                                              input logic [SAMPLES_W-1:0] samples);
        return HDR_BYTES + BYTES_PER_PAIR * (int'(code) + 1) * int'(samples);
    endfunction

    // The word clock count is in tens of hertz. It snaps to a nominal rate
    // only when it lies strictly inside the window around that rate.
    function automatic rate_code_t nearest_rate_code(input logic [COUNT_W-1:0] count);
        int unsigned hz;
        hz = int'(count) * HZ_PER_COUNT;
        if (hz + SNAP_WINDOW > RATE_44K1_HZ && hz < RATE_44K1_HZ + SNAP_WINDOW)
            return RATE_44K1;
        if (hz + SNAP_WINDOW > RATE_48K_HZ && hz < RATE_48K_HZ + SNAP_WINDOW)
            return RATE_48K;
        if (hz + SNAP_WINDOW > RATE_88K2_HZ && hz < RATE_88K2_HZ + SNAP_WINDOW)
            return RATE_88K2;
        if (hz + SNAP_WINDOW > RATE_96K_HZ && hz < RATE_96K_HZ + SNAP_WINDOW)
            return RATE_96K;
        return RATE_NONE;
    endfunction

    function automatic void count_resync();
        if (resync_tally != '1)
            resync_tally++;
    endfunction

    // Advances the local tracker by one accepted packet word and returns the
    // status word that the block must answer with.
    function automatic out_word_t track_packet(input in_word_t pkt);
        out_word_t   res;
        int unsigned len;
        int unsigned limit;
        rate_code_t  code;
        res   = '0;
        len   = pkt.packet_length;
        limit = frame_len(pair_code_q, samples_q);
        if (len > PKT_MAX)
            len = PKT_MAX;

        // Failed and empty packets leave every piece of state alone.
        if (pkt.packet_ok && len != 0)
        begin
            if (pkt.start_marker == HDR_START && pkt.end_marker == HDR_END)
            begin
                code = nearest_rate_code(pkt.rate_count);
                res.header_seen = 1'b1;
                header_count++;
                // Only a change away from a known, matched rate is flagged.
                if (code != last_code && last_code != RATE_UNKNOWN && last_code != RATE_NONE)
                begin
                    res.rate_changed = 1'b1;
                    rate_flips++;
                end
                last_code  = code;
                held_level = pkt.fifo_level_byte;
                held_skip  = pkt.skip_word;
                held_full  = pkt.full_word;
                held_iso   = pkt.iso_err_word;
                // A header that lands inside a frame drops that frame.
                if (gathered == 0)
                    gathered = len;
                else
                begin
                    count_resync();
                    gathered = 0;
                end
            end
            else if (gathered > 0)
                gathered += len;
            else
                count_resync();

            if (gathered == limit)
            begin
                res.frame_complete = 1'b1;
                frames_done++;
                gathered = 0;
            end
            if (gathered > limit)
            begin
                count_resync();
                gathered = 0;
            end
        end

        case (last_code)
            RATE_44K1: res.rate_hz = RATE_HZ_W'(RATE_44K1_HZ);
            RATE_48K:  res.rate_hz = RATE_HZ_W'(RATE_48K_HZ);
            RATE_88K2: res.rate_hz = RATE_HZ_W'(RATE_88K2_HZ);
            RATE_96K:  res.rate_hz = RATE_HZ_W'(RATE_96K_HZ);
            default:   res.rate_hz = '0;
        endcase
        res.fifo_level      = held_level;
        res.out_skip_count  = held_skip;
        res.in_full_count   = held_full;
        res.iso_error_count = held_iso;
        res.resync_errors   = resync_tally;
        res.frame_progress  = PROGRESS_W'(gathered);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Packet generation
    // ------------------------------------------------------------------

    function automatic int unsigned at_most(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // A full-size chunk may be sent with any length at or above the packet
    // limit, since the block clamps it.
    function automatic logic [PKT_LEN_W-1:0] len_field(input int unsigned bytes);
        if (bytes == PKT_MAX && $urandom_range(1) == 1)
            return PKT_LEN_W'($urandom_range(LEN_FIELD_MAX, PKT_MAX));
        return PKT_LEN_W'(bytes);
    endfunction

    function automatic logic [COUNT_W-1:0] count_near(input int unsigned hz, input int offset);
        return COUNT_W'(int'(hz / HZ_PER_COUNT) + offset);
    endfunction

    // Mostly counts around the four nominal rates, reaching one step past
    // each edge of the window, plus some fully random counts.
    function automatic logic [COUNT_W-1:0] pick_rate();
        int offset;
        offset = int'($urandom_range(62)) - 31;
        case ($urandom_range(5))
            0:       return count_near(RATE_44K1_HZ, offset);
            1:       return count_near(RATE_48K_HZ, offset);
            2:       return count_near(RATE_88K2_HZ, offset);
            3:       return count_near(RATE_96K_HZ, offset);
            default: return COUNT_W'($urandom());
        endcase
    endfunction

    function automatic void put_pkt(input logic ok, input logic [PKT_LEN_W-1:0] len,
                                    input logic [MARKER_W-1:0] start,
                                    input logic [MARKER_W-1:0] stop,
                                    input logic [COUNT_W-1:0] rate, input fill_e fill);
        in_word_t pkt;
        pkt.packet_ok       = ok;
        pkt.packet_length   = len;
        pkt.start_marker    = start;
        pkt.end_marker      = stop;
        pkt.rate_count      = rate;
        pkt.fifo_level_byte = LEVEL_W'($urandom());
        pkt.skip_word       = COUNT_W'($urandom());
        pkt.full_word       = COUNT_W'($urandom());
        pkt.iso_err_word    = COUNT_W'($urandom());
        if (fill == FILL_ZERO)
        begin
            pkt.fifo_level_byte = '0;
            pkt.skip_word       = '0;
            pkt.full_word       = '0;
            pkt.iso_err_word    = '0;
        end
        else if (fill == FILL_ONES)
        begin
            pkt.fifo_level_byte = '1;
            pkt.skip_word       = '1;
            pkt.full_word       = '1;
            pkt.iso_err_word    = '1;
        end
        packets_to_send.push_back(pkt);
        queued_total++;
    endfunction

    function automatic void put_head(input int unsigned bytes);
        put_pkt(1'b1, len_field(bytes), HDR_START, HDR_END, pick_rate(), FILL_RANDOM);
    endfunction

    // Data packets often carry one of the two header markers, so that near
    // misses of the header pattern show up regularly.
    function automatic void put_data(input int unsigned bytes);
        logic [MARKER_W-1:0] s;
        logic [MARKER_W-1:0] e;
        s = MARKER_W'($urandom());
        e = MARKER_W'($urandom());
        case ($urandom_range(4))
            0:       s = HDR_START;
            1:       e = HDR_END;
            default: ;
        endcase
        if (s == HDR_START && e == HDR_END)
            e = ~e;
        put_pkt(1'b1, len_field(bytes), s, e, COUNT_W'($urandom()), FILL_RANDOM);
    endfunction

    // Failed or empty packets, half of them shaped like a header.
    function automatic void put_noise();
        logic [MARKER_W-1:0] s;
        logic [MARKER_W-1:0] e;
        s = HDR_START;
        e = HDR_END;
        if ($urandom_range(1) == 1)
        begin
            s = MARKER_W'($urandom());
            e = MARKER_W'($urandom());
        end
        if ($urandom_range(1) == 1)
            put_pkt(1'b0, PKT_LEN_W'($urandom()), s, e, pick_rate(), FILL_RANDOM);
        else
            put_pkt(1'b1, '0, s, e, pick_rate(), FILL_RANDOM);
    endfunction

    // One header followed by data packets at the current frame size. A cut
    // frame stops early; an overrun frame ends with a packet too long.
    function automatic void put_frame(input frame_shape_e shape);
        int unsigned total;
        int unsigned cap;
        int unsigned first;
        int unsigned left;
        int unsigned chunk;
        total = frame_len(pair_code_q, samples_q);
        if (shape == FRAME_OVERRUN && total < PKT_MAX && $urandom_range(2) == 0)
        begin
            put_head($urandom_range(PKT_MAX, total + 1));
            return;
        end
        cap = (shape == FRAME_WHOLE) ? at_most(total, PKT_MAX) : at_most(total - 1, PKT_MAX);
        first = ($urandom_range(3) == 0) ? HDR_BYTES : $urandom_range(cap, 1);
        if (first > cap)
            first = cap;
        put_head(first);
        left = total - first;
        while (left != 0)
        begin
            if ($urandom_range(9) == 0)
                put_noise();
            cap = (shape == FRAME_WHOLE) ? at_most(left, PKT_MAX) : at_most(left - 1, PKT_MAX);
            if (shape == FRAME_OVERRUN && left < PKT_MAX)
            begin
                put_data($urandom_range(PKT_MAX, left + 1));
                left = 0;
            end
            else if (cap == 0)
                left = 0;
            else
            begin
                chunk = ($urandom_range(1) == 1) ? cap : $urandom_range(cap, 1);
                put_data(chunk);
                left -= chunk;
                if (shape == FRAME_CUT && $urandom_range(2) == 0)
                    left = 0;
            end
        end
    endfunction

    // Mostly well-formed frames with random content; the rest are broken
    // frames, stray data packets and noise.
    function automatic void queue_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        start = queued_total;
        while (queued_total - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 68)
                put_frame(FRAME_WHOLE);
            else if (pick < 78)
                put_frame(FRAME_CUT);
            else if (pick < 88)
                put_frame(FRAME_OVERRUN);
            else if (pick < 94)
                put_data($urandom_range(PKT_MAX, 1));
            else
                put_noise();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus process
    // ------------------------------------------------------------------

    // Writes both registers back to back. Valid stays high across the two
    // words, so it is raised once and lowered once. The upper bits of the
    // pair code word are filled at random, since only the low four count.
    task automatic configure(input int unsigned code, input int unsigned samples);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom());
        word[PAIR_CODE_W-1:0] = PAIR_CODE_W'(code);
        cfg_valid <= 1'b1;
        cfg_index <= REG_IN_PAIR_CODE;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
        pair_code_q = PAIR_CODE_W'(code);
        cfg_index <= REG_SAMPLES;
        cfg_data  <= SAMPLES_W'(samples);
        do @(posedge clk); while (!cfg_ready);
        samples_q = SAMPLES_W'(samples);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Returns once every queued word has come back, plus a short settle.
    task automatic wait_idle();
        do @(posedge clk); while (checked_total != queued_total);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset setting: a 402-byte frame.
        // A failed header and an empty header are both ignored.
        put_pkt(1'b0, PKT_LEN_W'(LEN_FIELD_MAX), HDR_START, HDR_END,
                count_near(RATE_44K1_HZ, 0), FILL_ONES);
        put_pkt(1'b1, '0, HDR_START, HDR_END, count_near(RATE_48K_HZ, 0), FILL_RANDOM);
        // Data with no frame open counts a resync.
        put_pkt(1'b1, 11'd5, 16'h1234, HDR_END, '0, FILL_RANDOM);
        // A header only frame start, then the rest of the frame in one packet.
        put_pkt(1'b1, 11'd18, HDR_START, HDR_END, count_near(RATE_44K1_HZ, 0), FILL_ZERO);
        put_pkt(1'b1, 11'd384, HDR_START, 16'h0000, '1, FILL_RANDOM);
        // An oversized header is clamped and overflows the frame; the rate
        // moves from 44.1 to 48 kHz.
        put_pkt(1'b1, PKT_LEN_W'(LEN_FIELD_MAX), HDR_START, HDR_END,
                count_near(RATE_48K_HZ, 0), FILL_ONES);
        // Just outside the low edge of the window: no match.
        put_pkt(1'b1, 11'd100, HDR_START, HDR_END, count_near(RATE_44K1_HZ, -30), FILL_RANDOM);
        // Header in the middle of a frame, just inside the low edge.
        put_pkt(1'b1, 11'd50, HDR_START, HDR_END, count_near(RATE_44K1_HZ, -29), FILL_RANDOM);
        // Just inside the high edge, then a frame filled in two data packets.
        put_pkt(1'b1, 11'd10, HDR_START, HDR_END, count_near(RATE_44K1_HZ, 29), FILL_ONES);
        put_pkt(1'b1, 11'd1, 16'hFFFF, 16'hFFFF, '0, FILL_RANDOM);
        put_pkt(1'b1, 11'd391, 16'h0000, 16'h0000, '0, FILL_ZERO);
        // Just outside the high edge, and a full-size header that overflows.
        put_pkt(1'b1, 11'd1024, HDR_START, HDR_END, count_near(RATE_44K1_HZ, 30), FILL_RANDOM);
        put_pkt(1'b1, 11'd200, HDR_START, HDR_END, count_near(RATE_96K_HZ, 29), FILL_RANDOM);
        // A data packet that runs past the end of the frame.
        put_pkt(1'b1, 11'd300, 16'hAAAB, HDR_END, '0, FILL_RANDOM);
        put_pkt(1'b1, 11'd20, HDR_START, HDR_END, count_near(RATE_96K_HZ, 30), FILL_RANDOM);
        put_pkt(1'b1, 11'd20, HDR_START, HDR_END, count_near(RATE_88K2_HZ, 0), FILL_RANDOM);
        put_pkt(1'b1, 11'd40, HDR_START, HDR_END, count_near(RATE_88K2_HZ, 0), FILL_RANDOM);
        // A failed data packet changes nothing; swapped markers are data.
        put_pkt(1'b0, 11'd362, 16'h0000, 16'h0000, '0, FILL_RANDOM);
        put_pkt(1'b1, 11'd362, HDR_END, HDR_START, '0, FILL_RANDOM);
        put_pkt(1'b1, 11'd1, HDR_START, HDR_END, '1, FILL_RANDOM);
        put_pkt(1'b1, 11'd401, 16'h0000, 16'hFFFF, '0, FILL_RANDOM);
        put_pkt(1'b1, 11'd1023, HDR_START, HDR_END, '0, FILL_RANDOM);
        wait_idle();

        // Extremes of the two registers. Zero samples leaves an 18-byte
        // frame, and the largest setting gives the longest frame.
        configure(0, 0);
        queue_traffic(120);
        wait_idle();
        configure(15, 255);
        queue_traffic(70);
        wait_idle();
        configure(0, 1);
        queue_traffic(120);
        wait_idle();
        configure(15, 0);
        queue_traffic(60);
        wait_idle();
        configure(0, 255);
        queue_traffic(120);
        wait_idle();
        configure(15, 1);
        queue_traffic(120);
        wait_idle();

        // Random settings, kept to short frames.
        for (phase = 0; phase < 6; phase++)
        begin
            configure($urandom_range(15), $urandom_range(40, 1));
            queue_traffic(150);
            wait_idle();
        end

        configure(PAIR_CODE_RST, SAMPLES_RST);
        queue_traffic(30);
        wait_idle();

        if (status_due.size() != 0)
        begin
            $error("%0d status words never arrived", status_due.size());
            failures++;
        end
        $display("Covered %0d packet words over %0d register settings, %0d headers,",
                 queued_total, settings_done, header_count);
        $display("%0d completed frames, %0d rate changes, %0d resync events, %0d mismatches.",
                 frames_done, rate_flips, resync_tally, failures);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------

    // Outside the calm window each side skips about one cycle in three.
    function automatic bit skip_this_cycle();
        if (checked_total >= CALM_FROM && checked_total < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    // The driver predicts on every accepted word, then offers the next one
    // whenever the current one has gone or none was on offer, unless it skips.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                status_due.push_back(track_packet(in_data));
            if (!in_valid || in_ready)
            begin
                if (packets_to_send.size() != 0 && !skip_this_cycle())
                begin
                    in_valid <= 1'b1;
                    in_data  <= packets_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void match_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    // The monitor checks each accepted status word against the oldest
    // prediction. Once, with a deep backlog at the sender, it holds off for
    // a long stretch so that the block fills up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin : status_check
        out_word_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status word arrived with nothing outstanding");
                    failures++;
                end
                else
                begin
                    want = status_due.pop_front();
                    match_field("frame_complete", want.frame_complete, out_data.frame_complete);
                    match_field("header_seen", want.header_seen, out_data.header_seen);
                    match_field("rate_hz", want.rate_hz, out_data.rate_hz);
                    match_field("rate_changed", want.rate_changed, out_data.rate_changed);
                    match_field("fifo_level", want.fifo_level, out_data.fifo_level);
                    match_field("out_skip_count", want.out_skip_count, out_data.out_skip_count);
                    match_field("in_full_count", want.in_full_count, out_data.in_full_count);
                    match_field("iso_error_count", want.iso_error_count,
                                out_data.iso_error_count);
                    match_field("resync_errors", want.resync_errors, out_data.resync_errors);
                    match_field("frame_progress", want.frame_progress, out_data.frame_progress);
                    checked_total++;
                end
            end
            if (!held_once && checked_total > HOLD_AFTER &&
                packets_to_send.size() > HOLD_BACKLOG)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !skip_this_cycle();
        end
    end

    // Safety net: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hdl/isofr_pkg.sv
hdl/isofr_in_stage.sv
hdl/isofr_cfg.sv
hdl/isofr_tracker.sv
hdl/iso_frame_reassembler_core.sv
hdl/isofr_checker.sv
tb/sv/tb_iso_frame_reassembler_core.sv
